[rtl/core/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants, register codes and types for the ray/triangle
// intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_BITS_DEF  = 24;
    localparam int TRI_ID_BITS_DEF = 16;

    localparam int DIV_BITS   = 32;
    localparam int FRAC_SHIFT = 16;
    localparam int ADDR_BITS  = 6;
    localparam int DATA_BITS  = 64;

    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X = 3'd3;
    localparam logic [2:0] REG_DIR_Y = 3'd4;
    localparam logic [2:0] REG_DIR_Z = 3'd5;
    localparam logic [2:0] REG_DET_MIN = 3'd6;
    localparam logic [2:0] REG_HIT_EPS = 3'd7;

    localparam logic [31:0] DIR_Z_RST   = 32'd4096;
    localparam logic [47:0] DET_MIN_RST = 48'd6871947;
    localparam logic [15:0] HIT_EPS_RST = 16'd1;

    localparam logic [31:0] NEG_LIM = 32'h8000_0000;
    localparam logic [31:0] POS_LIM = 32'h7FFF_FFFF;

    localparam logic [1:0] CLS_MISS   = 2'd0;
    localparam logic [1:0] CLS_AHEAD  = 2'd1;
    localparam logic [1:0] CLS_BEHIND = 2'd2;

    typedef struct packed {
        logic ok;
        logic neg;
        logic ovf;
    } rti_flags_t;

endpackage

[rtl/core/rti_div.sv]
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider: one overflow check stage, then one
// quotient bit per stage. Advances only when en is high.
// ----------------------------------------------------------------------------
module rti_div #(
    parameter int NW    = 128,
    parameter int TAG_W = 17
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  rti_pkg::rti_flags_t       in_flags,
    input  logic [TAG_W-1:0]          in_tag,
    input  logic [NW-1:0]             in_num,
    input  logic [NW-1:0]             in_den,
    output logic                      out_valid,
    output rti_pkg::rti_flags_t       out_flags,
    output logic [TAG_W-1:0]          out_tag,
    output logic [rti_pkg::DIV_BITS-1:0] out_quo
);

    localparam int QB = rti_pkg::DIV_BITS;

    logic                vld_reg [QB+1];
    rti_pkg::rti_flags_t flg_reg [QB+1];
    logic [TAG_W-1:0]    tag_reg [QB+1];
    logic [NW-1:0]       rem_reg [QB+1];
    logic [NW-1:0]       den_reg [QB+1];
    logic [QB-1:0]       quo_reg [QB+1];

    rti_pkg::rti_flags_t flg0_next;

    always_comb
    begin
        flg0_next     = in_flags;
        flg0_next.ovf = (in_num >= (in_den << QB));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_reg[0] <= flg0_next;
            tag_reg[0] <= in_tag;
            rem_reg[0] <= in_num;
            den_reg[0] <= in_den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [NW-1:0] sh;
        logic          take;
        logic [NW-1:0] rem_next;
        logic [QB-1:0] quo_next;

        always_comb
        begin
            sh       = den_reg[k] << (QB - 1 - k);
            take     = (rem_reg[k] >= sh);
            rem_next = take ? (rem_reg[k] - sh) : rem_reg[k];
            quo_next = quo_reg[k];
            quo_next[QB-1-k] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flg_reg[k+1] <= flg_reg[k];
                tag_reg[k+1] <= tag_reg[k];
                rem_reg[k+1] <= rem_next;
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= quo_next;
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign out_flags = flg_reg[QB];
    assign out_tag   = tag_reg[QB];
    assign out_quo   = quo_reg[QB];

endmodule

[rtl/core/ray_triangle_intersect.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray/triangle test against one ray held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   Load the ray origin, direction, det_min and hit_eps over the APB port
//   while no request is in flight. Then stream triangle requests on
//   in_valid/in_ready; each carries three corners, tri_id and tri_last.
//   Each request yields exactly one result on out_valid/out_ready, in order:
//   hit_tri, distance (Q16.16, zero on miss), hit_class and out_last.
//   Throughput: one request per cycle while the output is not stalled.
//   Pipeline: 8 arithmetic stages, 33 divider stages and one output
//   register lie between acceptance and out_valid; the 32 quotient bits of
//   the distance divide, one per stage, take up most of those stages.
//   Stall: when out_ready is low with a result waiting, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
//   Reset: rst_n clears all valid bits and loads the register defaults
//   (origin 0, direction +z, det_min about 1e-4, hit_eps 1).
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
    parameter int COORD_BITS  = rti_pkg::COORD_BITS_DEF,
    parameter int TRI_ID_BITS = rti_pkg::TRI_ID_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rti_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [rti_pkg::DATA_BITS-1:0]  pwdata,
    output logic [rti_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_BITS-1:0]   a_x,
    input  logic signed [COORD_BITS-1:0]   a_y,
    input  logic signed [COORD_BITS-1:0]   a_z,
    input  logic signed [COORD_BITS-1:0]   b_x,
    input  logic signed [COORD_BITS-1:0]   b_y,
    input  logic signed [COORD_BITS-1:0]   b_z,
    input  logic signed [COORD_BITS-1:0]   c_x,
    input  logic signed [COORD_BITS-1:0]   c_y,
    input  logic signed [COORD_BITS-1:0]   c_z,
    input  logic [TRI_ID_BITS-1:0]         tri_id,
    input  logic                           tri_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [TRI_ID_BITS-1:0]         hit_tri,
    output logic signed [31:0]             distance,
    output logic [1:0]                     hit_class,
    output logic                           out_last
);

    localparam int C     = COORD_BITS;
    localparam int EW    = C + 1;
    localparam int PAW   = 2 * C + 1;
    localparam int QAW   = 2 * C + 2;
    localparam int PW    = 2 * C + 2;
    localparam int QW    = 2 * C + 3;
    localparam int HW    = QW - (C + 1);
    localparam int PPW   = EW + HW;
    localparam int FW    = 3 * C + 4;
    localparam int DW    = 3 * C + 6;
    localparam int NW    = DW + rti_pkg::DIV_BITS + 1;
    localparam int TAG_W = TRI_ID_BITS + 1;
    localparam int NS    = 8;
    localparam int QB    = rti_pkg::DIV_BITS;

    // Configuration registers
    logic signed [C-1:0] org_reg [3];
    logic signed [C-1:0] dir_reg [3];
    logic [47:0]         det_min_reg;
    logic [15:0]         hit_eps_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0]  <= '0;
            org_reg[1]  <= '0;
            org_reg[2]  <= '0;
            dir_reg[0]  <= '0;
            dir_reg[1]  <= '0;
            dir_reg[2]  <= rti_pkg::DIR_Z_RST[C-1:0];
            det_min_reg <= rti_pkg::DET_MIN_RST;
            hit_eps_reg <= rti_pkg::HIT_EPS_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[5:3])
                rti_pkg::REG_ORG_X:   org_reg[0]  <= pwdata[C-1:0];
                rti_pkg::REG_ORG_Y:   org_reg[1]  <= pwdata[C-1:0];
                rti_pkg::REG_ORG_Z:   org_reg[2]  <= pwdata[C-1:0];
                rti_pkg::REG_DIR_X:   dir_reg[0]  <= pwdata[C-1:0];
                rti_pkg::REG_DIR_Y:   dir_reg[1]  <= pwdata[C-1:0];
                rti_pkg::REG_DIR_Z:   dir_reg[2]  <= pwdata[C-1:0];
                rti_pkg::REG_DET_MIN: det_min_reg <= pwdata[47:0];
                rti_pkg::REG_HIT_EPS: hit_eps_reg <= pwdata[15:0];
                default:              hit_eps_reg <= hit_eps_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            rti_pkg::REG_ORG_X:   prdata = rti_pkg::DATA_BITS'($unsigned(org_reg[0]));
            rti_pkg::REG_ORG_Y:   prdata = rti_pkg::DATA_BITS'($unsigned(org_reg[1]));
            rti_pkg::REG_ORG_Z:   prdata = rti_pkg::DATA_BITS'($unsigned(org_reg[2]));
            rti_pkg::REG_DIR_X:   prdata = rti_pkg::DATA_BITS'($unsigned(dir_reg[0]));
            rti_pkg::REG_DIR_Y:   prdata = rti_pkg::DATA_BITS'($unsigned(dir_reg[1]));
            rti_pkg::REG_DIR_Z:   prdata = rti_pkg::DATA_BITS'($unsigned(dir_reg[2]));
            rti_pkg::REG_DET_MIN: prdata = rti_pkg::DATA_BITS'(det_min_reg);
            rti_pkg::REG_HIT_EPS: prdata = rti_pkg::DATA_BITS'(hit_eps_reg);
            default:              prdata = '0;
        endcase
    end

    // Pipeline control
    logic en;
    logic             vld_reg [NS];
    logic [TAG_W-1:0] tag_reg [NS];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= {tri_last, tri_id};
            for (int s = 1; s < NS; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    // Stage 1: edges and origin offset
    logic signed [EW-1:0] e1_s1_reg [3];
    logic signed [EW-1:0] e2_s1_reg [3];
    logic signed [EW-1:0] tp_s1_reg [3];
    logic signed [C-1:0]  av [3];
    logic signed [C-1:0]  bv [3];
    logic signed [C-1:0]  cv [3];

    assign av[0] = a_x;
    assign av[1] = a_y;
    assign av[2] = a_z;
    assign bv[0] = b_x;
    assign bv[1] = b_y;
    assign bv[2] = b_z;
    assign cv[0] = c_x;
    assign cv[1] = c_y;
    assign cv[2] = c_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_s1_reg[i] <= EW'(bv[i]) - EW'(av[i]);
                e2_s1_reg[i] <= EW'(cv[i]) - EW'(av[i]);
                tp_s1_reg[i] <= EW'(org_reg[i]) - EW'(av[i]);
            end
        end
    end

    // Stage 2: cross product terms
    logic signed [PAW-1:0] pa_reg [3];
    logic signed [PAW-1:0] pb_reg [3];
    logic signed [QAW-1:0] qa_reg [3];
    logic signed [QAW-1:0] qb_reg [3];
    logic signed [EW-1:0]  e1_s2_reg [3];
    logic signed [EW-1:0]  e2_s2_reg [3];
    logic signed [EW-1:0]  tp_s2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= dir_reg[(i+1)%3] * e2_s1_reg[(i+2)%3];
                pb_reg[i] <= dir_reg[(i+2)%3] * e2_s1_reg[(i+1)%3];
                qa_reg[i] <= tp_s1_reg[(i+1)%3] * e1_s1_reg[(i+2)%3];
                qb_reg[i] <= tp_s1_reg[(i+2)%3] * e1_s1_reg[(i+1)%3];
                e1_s2_reg[i] <= e1_s1_reg[i];
                e2_s2_reg[i] <= e2_s1_reg[i];
                tp_s2_reg[i] <= tp_s1_reg[i];
            end
        end
    end

    // Stage 3: p = dir x e2, q = t x e1
    logic signed [PW-1:0] p_reg [3];
    logic signed [QW-1:0] q_reg [3];
    logic signed [EW-1:0] e1_s3_reg [3];
    logic signed [EW-1:0] e2_s3_reg [3];
    logic signed [EW-1:0] tp_s3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i] <= PW'(pa_reg[i]) - PW'(pb_reg[i]);
                q_reg[i] <= QW'(qa_reg[i]) - QW'(qb_reg[i]);
                e1_s3_reg[i] <= e1_s2_reg[i];
                e2_s3_reg[i] <= e2_s2_reg[i];
                tp_s3_reg[i] <= tp_s2_reg[i];
            end
        end
    end

    // Stage 4: split partial products for det, u, v and num
    logic signed [EW-1:0]  nar [4][3];
    logic signed [QW-1:0]  wid [4][3];
    logic signed [PPW-1:0] ph_next [4][3];
    logic signed [PPW-1:0] pl_next [4][3];
    logic signed [PPW-1:0] ph_reg [4][3];
    logic signed [PPW-1:0] pl_reg [4][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nar[0][i] = e1_s3_reg[i];
            wid[0][i] = QW'(p_reg[i]);
            nar[1][i] = tp_s3_reg[i];
            wid[1][i] = QW'(p_reg[i]);
            nar[2][i] = EW'(dir_reg[i]);
            wid[2][i] = q_reg[i];
            nar[3][i] = e2_s3_reg[i];
            wid[3][i] = q_reg[i];
        end
        for (int d = 0; d < 4; d++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ph_next[d][i] = nar[d][i] * $signed(wid[d][i][QW-1:C+1]);
                pl_next[d][i] = nar[d][i] * $signed({1'b0, wid[d][i][C:0]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
        end
    end

    // Stage 5: merge partial products
    logic signed [FW-1:0] full_reg [4][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int d = 0; d < 4; d++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    full_reg[d][i] <= (FW'(ph_reg[d][i]) <<< (C + 1)) + FW'(pl_reg[d][i]);
                end
            end
        end
    end

    // Stage 6: dot products
    logic signed [DW-1:0] dot_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int d = 0; d < 4; d++)
            begin
                dot_reg[d] <= DW'(full_reg[d][0]) + DW'(full_reg[d][1])
                            + DW'(full_reg[d][2]);
            end
        end
    end

    // Stage 7: fold the determinant sign
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] u_reg;
    logic signed [DW-1:0] v_reg;
    logic signed [DW-1:0] num_reg;
    logic                 pos;

    assign pos = (dot_reg[0] > 0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= pos ? dot_reg[0] : -dot_reg[0];
            u_reg   <= pos ? dot_reg[1] : -dot_reg[1];
            v_reg   <= pos ? dot_reg[2] : -dot_reg[2];
            num_reg <= pos ? dot_reg[3] : -dot_reg[3];
        end
    end

    // Stage 8: range checks and divider operands
    logic [DW+47:0]        det_x;
    logic [DW+47:0]        min_x;
    logic signed [DW:0]    uv_sum;
    logic                  ok;
    logic                  neg;
    logic [DW-1:0]         nabs;
    rti_pkg::rti_flags_t   flg_reg;
    logic [NW-1:0]         dnum_reg;
    logic [NW-1:0]         dden_reg;

    always_comb
    begin
        det_x  = (DW+48)'($unsigned(det_reg));
        min_x  = (DW+48)'(det_min_reg);
        uv_sum = (DW+1)'(u_reg) + (DW+1)'(v_reg);
        ok     = (det_reg != 0) && (det_x >= min_x)
              && !u_reg[DW-1] && (u_reg <= det_reg)
              && !v_reg[DW-1] && (uv_sum <= (DW+1)'(det_reg));
        neg    = num_reg[DW-1];
        nabs   = neg ? DW'($unsigned(-num_reg)) : DW'($unsigned(num_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_reg.ok  <= ok;
            flg_reg.neg <= neg;
            flg_reg.ovf <= 1'b0;
            dnum_reg    <= NW'(nabs) << rti_pkg::FRAC_SHIFT;
            dden_reg    <= NW'($unsigned(det_reg));
        end
    end

    // Distance divide
    logic                dv_valid;
    rti_pkg::rti_flags_t dv_flags;
    logic [TAG_W-1:0]    dv_tag;
    logic [QB-1:0]       dv_quo;

    rti_div #(
        .NW    (NW),
        .TAG_W (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[NS-1]),
        .in_flags  (flg_reg),
        .in_tag    (tag_reg[NS-1]),
        .in_num    (dnum_reg),
        .in_den    (dden_reg),
        .out_valid (dv_valid),
        .out_flags (dv_flags),
        .out_tag   (dv_tag),
        .out_quo   (dv_quo)
    );

    // Output stage: saturate and classify
    logic [31:0]       mag;
    logic              hit;
    logic [31:0]       dist_next;
    logic [1:0]        cls_next;
    logic              out_valid_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [31:0]       dist_reg;
    logic [1:0]        cls_reg;

    always_comb
    begin
        if (dv_flags.neg)
        begin
            mag = (dv_flags.ovf || dv_quo > rti_pkg::NEG_LIM) ? rti_pkg::NEG_LIM : dv_quo;
        end
        else
        begin
            mag = (dv_flags.ovf || dv_quo > rti_pkg::POS_LIM) ? rti_pkg::POS_LIM : dv_quo;
        end
        hit = dv_flags.ok && (mag > 32'(hit_eps_reg));
        if (!hit)
        begin
            dist_next = '0;
            cls_next  = rti_pkg::CLS_MISS;
        end
        else if (dv_flags.neg)
        begin
            dist_next = -mag;
            cls_next  = rti_pkg::CLS_BEHIND;
        end
        else
        begin
            dist_next = mag;
            cls_next  = rti_pkg::CLS_AHEAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_tag_reg <= dv_tag;
            dist_reg    <= dist_next;
            cls_reg     <= cls_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_tri   = out_tag_reg[TRI_ID_BITS-1:0];
    assign out_last  = out_tag_reg[TRI_ID_BITS];
    assign distance  = $signed(dist_reg);
    assign hit_class = cls_reg;

endmodule
